// ----- rtl/hdip_pkg.sv -----
// ----------------------------------------------------------------------------
// hdip_pkg
// Shared types, codes and helpers for the HID descriptor item parser.
// ----------------------------------------------------------------------------
package hdip_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0]  MAX_ITEMS_RESET = 8'd20;
    localparam logic [31:0] VENDOR_PAGE_MIN = 32'h0000_FF00;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ITEM    = 2'd0,
        KIND_TRUNC   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    // item types from prefix bits 3:2
    typedef enum logic [1:0] {
        TYPE_MAIN     = 2'd0,
        TYPE_GLOBAL   = 2'd1,
        TYPE_LOCAL    = 2'd2,
        TYPE_RESERVED = 2'd3
    } t_item_type;

    // tags
    localparam logic [3:0] TAG_USAGE_PAGE   = 4'h0;
    localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
    localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
    localparam logic [3:0] TAG_USAGE        = 4'h0;
    localparam logic [3:0] TAG_INPUT        = 4'h8;
    localparam logic [3:0] TAG_OUTPUT       = 4'h9;
    localparam logic [3:0] TAG_COLLECTION   = 4'hA;
    localparam logic [3:0] TAG_FEATURE      = 4'hB;
    localparam logic [3:0] TAG_END_COLL     = 4'hC;

    typedef enum logic [3:0] {
        CLS_OTHER        = 4'd0,
        CLS_USAGE_PAGE   = 4'd1,
        CLS_USAGE        = 4'd2,
        CLS_COLLECTION   = 4'd3,
        CLS_END_COLL     = 4'd4,
        CLS_INPUT        = 4'd5,
        CLS_OUTPUT       = 4'd6,
        CLS_FEATURE      = 4'd7,
        CLS_REPORT_SIZE  = 4'd8,
        CLS_REPORT_COUNT = 4'd9,
        CLS_REPORT_ID    = 4'd10
    } t_class;

    // one queue entry: optional item/truncation beat plus optional summary
    typedef struct packed {
        logic        has_item;
        t_kind       kind;
        logic [15:0] offset;
        logic [1:0]  itype;
        logic [3:0]  tag;
        logic [31:0] data;
        t_class      cls;
        logic [31:0] page;
        logic        page_seen;
        logic        has_sum;
    } t_event;

    // one output beat
    typedef struct packed {
        t_kind       kind;
        logic [15:0] offset;
        logic [1:0]  itype;
        logic [3:0]  tag;
        logic [31:0] data;
        t_class      cls;
        logic [31:0] page;
        logic        page_seen;
        logic        vendor;
        logic        last;
    } t_beat;

    function automatic logic [2:0] size_of(input logic [7:0] prefix);
        logic [2:0] s;
        s = {1'b0, prefix[1:0]};
        if (s == 3'd3) begin
            s = 3'd4;
        end
        return s;
    endfunction

    function automatic t_class class_of(input logic [1:0] itype, input logic [3:0] tag);
        t_class c;
        c = CLS_OTHER;
        case (itype)
            TYPE_GLOBAL: begin
                if (tag == TAG_USAGE_PAGE) c = CLS_USAGE_PAGE;
                else if (tag == TAG_REPORT_SIZE) c = CLS_REPORT_SIZE;
                else if (tag == TAG_REPORT_COUNT) c = CLS_REPORT_COUNT;
                else if (tag == TAG_REPORT_ID) c = CLS_REPORT_ID;
            end
            TYPE_LOCAL: begin
                if (tag == TAG_USAGE) c = CLS_USAGE;
            end
            TYPE_MAIN: begin
                if (tag == TAG_COLLECTION) c = CLS_COLLECTION;
                else if (tag == TAG_END_COLL) c = CLS_END_COLL;
                else if (tag == TAG_INPUT) c = CLS_INPUT;
                else if (tag == TAG_OUTPUT) c = CLS_OUTPUT;
                else if (tag == TAG_FEATURE) c = CLS_FEATURE;
            end
            default: begin
                c = CLS_OTHER;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/hdip_in_if.sv -----
// ----------------------------------------------------------------------------
// hdip_in_if
// Descriptor byte channel: valid/ready with byte and end mark.
// ----------------------------------------------------------------------------
interface hdip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_descriptor;

    modport source (output valid, output in_byte, output end_of_descriptor, input ready);
    modport sink   (input valid, input in_byte, input end_of_descriptor, output ready);
endinterface

// ----- rtl/hdip_out_if.sv -----
// ----------------------------------------------------------------------------
// hdip_out_if
// Result channel: valid/ready with one parsed result per beat.
// ----------------------------------------------------------------------------
interface hdip_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] item_offset;
    logic [1:0]  item_type;
    logic [3:0]  item_tag;
    logic [31:0] item_data;
    logic [3:0]  item_class;
    logic [31:0] current_page;
    logic        page_seen;
    logic        vendor_defined;
    logic        last_result;

    modport source (
        output valid, output result_kind, output item_offset, output item_type,
        output item_tag, output item_data, output item_class, output current_page,
        output page_seen, output vendor_defined, output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input item_offset, input item_type,
        input item_tag, input item_data, input item_class, input current_page,
        input page_seen, input vendor_defined, input last_result, output ready
    );
endinterface

// ----- rtl/hdip_front.sv -----
// ----------------------------------------------------------------------------
// hdip_front
// Byte parser: splits bytes into short items, tracks page, emits events.
// ----------------------------------------------------------------------------
module hdip_front
    import hdip_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hdip_in_if.sink      i_in,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    input  logic         i_full,
    output logic         o_push,
    output t_event       o_event
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic [7:0]             r_max;
    logic [2:0]             r_pend,     n_pend;
    logic [7:0]             r_prefix,   n_prefix;
    logic [31:0]            r_acc,      n_acc;
    logic [OFFSET_BITS-1:0] r_pos,      n_pos;
    logic [OFFSET_BITS-1:0] r_start,    n_start;
    logic [7:0]             r_reported, n_reported;
    logic [31:0]            r_page,     n_page;
    logic                   r_pvalid,   n_pvalid;

    logic       accept;
    logic       complete;
    logic       room;
    logic [1:0] idx;
    logic [2:0] held_size;
    t_class     cls;
    t_event     ev;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_pend     = r_pend;
        n_prefix   = r_prefix;
        n_acc      = r_acc;
        n_pos      = r_pos;
        n_start    = r_start;
        n_reported = r_reported;
        n_page     = r_page;
        n_pvalid   = r_pvalid;
        ev         = '0;
        held_size  = size_of(r_prefix);
        idx        = 2'(held_size - r_pend);
        complete   = 1'b0;
        room       = r_reported < r_max;
        cls        = CLS_OTHER;
        o_push     = 1'b0;

        if (accept) begin
            if (r_pend == 3'd0) begin
                n_prefix = i_in.in_byte;
                n_start  = r_pos;
                n_acc    = '0;
                n_pend   = size_of(i_in.in_byte);
            end else begin
                n_acc  = r_acc | (32'(i_in.in_byte) << {idx, 3'b000});
                n_pend = r_pend - 3'd1;
            end
            complete = (n_pend == 3'd0);
            n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
            cls      = class_of(n_prefix[3:2], n_prefix[7:4]);

            if (complete && room) begin
                if (cls == CLS_USAGE_PAGE) begin
                    n_page   = n_acc;
                    n_pvalid = 1'b1;
                end
                n_reported  = r_reported + 8'd1;
                ev.has_item = 1'b1;
                ev.kind     = KIND_ITEM;
                ev.offset   = 16'(n_start);
                ev.itype    = n_prefix[3:2];
                ev.tag      = n_prefix[7:4];
                ev.data     = n_acc;
                ev.cls      = cls;
            end else if (i_in.end_of_descriptor && n_pend != 3'd0 && room) begin
                ev.has_item = 1'b1;
                ev.kind     = KIND_TRUNC;
                ev.offset   = 16'(n_start);
                ev.itype    = n_prefix[3:2];
                ev.tag      = n_prefix[7:4];
            end
            ev.page      = n_page;
            ev.page_seen = n_pvalid;
            ev.has_sum   = i_in.end_of_descriptor;
            o_push       = ev.has_item || i_in.end_of_descriptor;

            // descriptor closed: start afresh
            if (i_in.end_of_descriptor) begin
                n_pend     = '0;
                n_prefix   = '0;
                n_acc      = '0;
                n_pos      = '0;
                n_start    = '0;
                n_reported = '0;
                n_page     = '0;
                n_pvalid   = 1'b0;
            end
        end
    end

    assign o_event = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= MAX_ITEMS_RESET;
            r_pend     <= '0;
            r_prefix   <= '0;
            r_acc      <= '0;
            r_pos      <= '0;
            r_start    <= '0;
            r_reported <= '0;
            r_page     <= '0;
            r_pvalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_pend     <= n_pend;
            r_prefix   <= n_prefix;
            r_acc      <= n_acc;
            r_pos      <= n_pos;
            r_start    <= n_start;
            r_reported <= n_reported;
            r_page     <= n_page;
            r_pvalid   <= n_pvalid;
        end
    end

endmodule

// ----- rtl/hdip_queue.sv -----
// ----------------------------------------------------------------------------
// hdip_queue
// Small event queue between parser and output stage.
// ----------------------------------------------------------------------------
module hdip_queue
    import hdip_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    input  logic   i_pop,
    output t_event o_head,
    output logic   o_empty,
    output logic   o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_event        r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/hdip_back.sv -----
// ----------------------------------------------------------------------------
// hdip_back
// Output stage: expands events into beats into a registered output.
// ----------------------------------------------------------------------------
module hdip_back
    import hdip_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_event     i_head,
    input  logic       i_empty,
    output logic       o_pop,
    hdip_out_if.source o_out
);

    logic  r_valid;
    logic  r_phase, n_phase;
    t_beat r_beat,  n_beat;
    logic  load;
    logic  take;
    logic  item_first;

    assign load       = !r_valid || o_out.ready;
    assign take       = load && !i_empty;
    assign item_first = i_head.has_item && !r_phase;

    always_comb begin
        n_beat           = '0;
        n_beat.page      = i_head.page;
        n_beat.page_seen = i_head.page_seen;
        n_beat.vendor    = i_head.page_seen && (i_head.page >= VENDOR_PAGE_MIN);
        if (item_first) begin
            n_beat.kind   = i_head.kind;
            n_beat.offset = i_head.offset;
            n_beat.itype  = i_head.itype;
            n_beat.tag    = i_head.tag;
            n_beat.data   = i_head.data;
            n_beat.cls    = i_head.cls;
            n_beat.last   = !i_head.has_sum;
        end else begin
            n_beat.kind = KIND_SUMMARY;
            n_beat.last = 1'b1;
        end
        // item beat of an end byte leaves the summary still to go
        n_phase = r_phase;
        o_pop   = 1'b0;
        if (take) begin
            n_phase = item_first && i_head.has_sum;
            o_pop   = !(item_first && i_head.has_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat <= n_beat;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.result_kind    = r_beat.kind;
    assign o_out.item_offset    = r_beat.offset;
    assign o_out.item_type      = r_beat.itype;
    assign o_out.item_tag       = r_beat.tag;
    assign o_out.item_data      = r_beat.data;
    assign o_out.item_class     = r_beat.cls;
    assign o_out.current_page   = r_beat.page;
    assign o_out.page_seen      = r_beat.page_seen;
    assign o_out.vendor_defined = r_beat.vendor;
    assign o_out.last_result    = r_beat.last;

endmodule

// ----- rtl/hid_descriptor_item_parser_unit.sv -----
// ----------------------------------------------------------------------------
// hid_descriptor_item_parser_unit
// USB HID report descriptor short-item parser, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one descriptor byte per cycle; i_in.ready only drops when the event
// queue (QUEUE_DEPTH entries) is full. Each byte that completes an item under
// the max_items limit, or the end-marked byte, makes one queue entry; the output
// register drains one beat per cycle while o_out.ready is high, so an end byte
// that closes or truncates an item under the limit yields an item beat, then a
// summary beat. After an end byte the parse state clears at once, so the next
// descriptor may follow directly. The user writes max_items via i_cfg_we and
// i_cfg_wdata only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hid_descriptor_item_parser_unit
    import hdip_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hdip_in_if.sink    i_in,
    hdip_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_event ev_in;
    t_event ev_head;

    // front: byte split, item classification, usage page tracking
    hdip_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_event     (ev_in)
    );

    // decouples byte intake from output backpressure
    hdip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (ev_in),
        .i_pop   (pop),
        .o_head  (ev_head),
        .o_empty (empty),
        .o_full  (full)
    );

    // back: one or two beats per event into the output register
    hdip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (ev_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // no event is ever written into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("event pushed into full queue");

    // a pop never happens on an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("event popped from empty queue");

    // the summary beat always closes the byte's results
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == KIND_SUMMARY) |-> o_out.last_result)
        else $error("summary beat without last mark");

    // vendor flag only with a seen page
    a_vendor_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.vendor_defined) |-> o_out.page_seen)
        else $error("vendor flag without page");

endmodule

// ----- bench/hid_descriptor_item_parser_unit_test.sv -----
// ----------------------------------------------------------------------------
// hid_descriptor_item_parser_unit_test
// Self-checking bench for the HID descriptor short-item parser: a queued
// byte driver with random gaps, a stalling result monitor and an in-order
// item predictor. It runs through several item limits, zero and 255 among them.
// ----------------------------------------------------------------------------
module hid_descriptor_item_parser_unit_test;
    import hdip_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 8;    // drain margin for bytes still in flight

    typedef struct packed {
        logic [7:0] value;
        logic       eod;
    } t_desc_byte;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_wdata;

    hdip_in_if  in_if ();
    hdip_out_if out_if ();

    hid_descriptor_item_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    t_desc_byte byte_q[$];      // bytes still to be sent
    t_beat      result_q[$];    // predicted result beats, oldest first
    t_desc_byte next_byte;
    int         bytes_queued = 0;
    int         bytes_taken  = 0;
    int         cycle_count  = 0;
    int         send_gap     = 0;
    int         stall_left   = 0;
    logic       byte_taken   = 1'b0;
    logic       calm         = 1'b0;    // no idling on either side when set
    logic       failed       = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor state: mirror of the parser's own registers
    // ------------------------------------------------------------------------
    logic [7:0]  item_limit  = MAX_ITEMS_RESET;
    logic [2:0]  left_bytes  = '0;     // data bytes still owed, 0 = want prefix
    logic [7:0]  cur_prefix  = '0;
    logic [31:0] gathered    = '0;
    logic [15:0] next_pos    = '0;     // saturating byte offset
    logic [15:0] cur_start   = '0;
    logic [7:0]  items_done  = '0;
    logic [31:0] page_val    = '0;
    logic        page_ok     = 1'b0;

    // ------------------------------------------------------------------------
    // Clock and cycle guard
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, sometimes a long one; none at all in calm phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Prefix size code 3 means four data bytes.
    function automatic int bytes_after(input logic [7:0] prefix);
        return (prefix[1:0] == 2'd3) ? 4 : int'(prefix[1:0]);
    endfunction

    function automatic t_class class_for(input logic [1:0] ty, input logic [3:0] tg);
        case ({ty, tg})
            {TYPE_GLOBAL, TAG_USAGE_PAGE}:   return CLS_USAGE_PAGE;
            {TYPE_GLOBAL, TAG_REPORT_SIZE}:  return CLS_REPORT_SIZE;
            {TYPE_GLOBAL, TAG_REPORT_COUNT}: return CLS_REPORT_COUNT;
            {TYPE_GLOBAL, TAG_REPORT_ID}:    return CLS_REPORT_ID;
            {TYPE_LOCAL,  TAG_USAGE}:        return CLS_USAGE;
            {TYPE_MAIN,   TAG_COLLECTION}:   return CLS_COLLECTION;
            {TYPE_MAIN,   TAG_END_COLL}:     return CLS_END_COLL;
            {TYPE_MAIN,   TAG_INPUT}:        return CLS_INPUT;
            {TYPE_MAIN,   TAG_OUTPUT}:       return CLS_OUTPUT;
            {TYPE_MAIN,   TAG_FEATURE}:      return CLS_FEATURE;
            default:                         return CLS_OTHER;
        endcase
    endfunction

    // Page fields always reflect the state after this byte's item.
    function automatic t_beat make_result(input t_kind k, input logic [15:0] off,
                                          input logic [1:0] ty, input logic [3:0] tg,
                                          input logic [31:0] d, input t_class c);
        t_beat r;
        r.kind      = k;
        r.offset    = off;
        r.itype     = ty;
        r.tag       = tg;
        r.data      = d;
        r.cls       = c;
        r.page      = page_val;
        r.page_seen = page_ok;
        r.vendor    = page_ok && (page_val >= VENDOR_PAGE_MIN);
        r.last      = 1'b0;
        return r;
    endfunction

    // Predict the result beats of one accepted descriptor byte.
    task automatic parse_byte(input logic [7:0] b, input logic eod);
        t_beat      beats[2];
        int         n;
        int         idx;
        logic       done;
        logic       room;
        logic [1:0] ty;
        logic [3:0] tg;
        t_class     cl;

        n = 0;
        if (left_bytes == 0) begin
            cur_prefix = b;
            cur_start  = next_pos;
            gathered   = '0;
            left_bytes = 3'(bytes_after(b));
            done       = (left_bytes == 0);
        end else begin
            // little-endian gather
            idx        = (bytes_after(cur_prefix) - int'(left_bytes)) & 3;
            gathered   = gathered | (32'(b) << (8 * idx));
            left_bytes = left_bytes - 3'd1;
            done       = (left_bytes == 0);
        end
        if (next_pos != '1) next_pos = next_pos + 16'd1;

        ty   = cur_prefix[3:2];
        tg   = cur_prefix[7:4];
        room = (items_done < item_limit);
        if (done && room) begin
            cl = class_for(ty, tg);
            if (cl == CLS_USAGE_PAGE) begin
                page_val = gathered;
                page_ok  = 1'b1;
            end
            items_done = items_done + 8'd1;
            beats[n] = make_result(KIND_ITEM, cur_start, ty, tg, gathered, cl);
            n = n + 1;
        end else if (eod && left_bytes != 0 && room) begin
            // descriptor closed inside an item
            beats[n] = make_result(KIND_TRUNC, cur_start, ty, tg, '0, CLS_OTHER);
            n = n + 1;
        end

        if (eod) begin
            beats[n] = make_result(KIND_SUMMARY, '0, '0, '0, '0, CLS_OTHER);
            n = n + 1;
            left_bytes = '0;
            cur_prefix = '0;
            gathered   = '0;
            next_pos   = '0;
            cur_start  = '0;
            items_done = '0;
            page_val   = '0;
            page_ok    = 1'b0;
        end

        if (n > 0) beats[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) result_q.push_back(beats[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failed = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: posedge notes the accepted beat, negedge drives the next
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            parse_byte(in_if.in_byte, in_if.end_of_descriptor);
            bytes_taken++;
            byte_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        // hold a beat that is still waiting for ready
        if (!in_if.valid || byte_taken) begin
            byte_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                next_byte = byte_q.pop_front();
                in_if.in_byte           <= next_byte.value;
                in_if.end_of_descriptor <= next_byte.eod;
                in_if.valid             <= 1'b1;
                send_gap = pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls on ready, compare each beat in order
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_beat w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (result_q.size() == 0) begin
                $error("result beat with none expected: kind %0d offset 0x%0h",
                       out_if.result_kind, out_if.item_offset);
                failed = 1'b1;
            end else begin
                w = result_q.pop_front();
                check_field("result_kind",    32'(w.kind),      32'(out_if.result_kind));
                check_field("item_offset",    32'(w.offset),    32'(out_if.item_offset));
                check_field("item_type",      32'(w.itype),     32'(out_if.item_type));
                check_field("item_tag",       32'(w.tag),       32'(out_if.item_tag));
                check_field("item_data",      w.data,           out_if.item_data);
                check_field("item_class",     32'(w.cls),       32'(out_if.item_class));
                check_field("current_page",   w.page,           out_if.current_page);
                check_field("page_seen",      32'(w.page_seen), 32'(out_if.page_seen));
                check_field("vendor_defined", 32'(w.vendor),    32'(out_if.vendor_defined));
                check_field("last_result",    32'(w.last),      32'(out_if.last_result));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] value, input logic eod);
        t_desc_byte d;
        d.value = value;
        d.eod   = eod;
        byte_q.push_back(d);
        bytes_queued++;
    endtask

    // Prefix plus the first n_data data bytes; eod goes on the last byte sent,
    // so n_data below the prefix size makes a truncated item.
    task automatic add_item(input logic [7:0] prefix, input logic [31:0] data,
                            input int n_data, input logic eod);
        add_byte(prefix, eod && (n_data == 0));
        for (int j = 0; j < n_data; j++) add_byte(data[8*j +: 8], eod && (j == n_data - 1));
    endtask

    function automatic logic [7:0] random_prefix();
        logic [7:0] p;
        p = 8'($urandom);
        // lean on usage page so the page tracking gets exercised
        if ($urandom_range(0, 99) < 30) p[7:2] = {TAG_USAGE_PAGE, TYPE_GLOBAL};
        return p;
    endfunction

    function automatic logic [31:0] random_data();
        case ($urandom_range(0, 9))
            0:       return VENDOR_PAGE_MIN;
            1:       return VENDOR_PAGE_MIN - 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return 32'($urandom_range(0, 255));
            default: return 32'($urandom);
        endcase
    endfunction

    // One descriptor: mostly well formed, some cut short, some pure noise.
    task automatic make_descriptor();
        int         mix;
        int         n_items;
        int         n_noise;
        int         sz;
        logic [7:0] pre;
        logic       is_last;

        mix = $urandom_range(0, 99);
        if (mix < 10) begin
            n_noise = $urandom_range(1, 6);
            for (int k = 0; k < n_noise; k++) add_byte(8'($urandom), k == n_noise - 1);
        end else begin
            n_items = $urandom_range(1, 8);
            for (int i = 0; i < n_items; i++) begin
                pre     = random_prefix();
                sz      = bytes_after(pre);
                is_last = (i == n_items - 1);
                if (is_last && mix < 25 && sz > 0) begin
                    add_item(pre, random_data(), $urandom_range(0, sz - 1), 1'b1);
                end else begin
                    add_item(pre, random_data(), sz, is_last);
                end
            end
        end
    endtask

    // Idle means: every byte taken, every beat seen, then the pipe drained
    // (a byte that completes nothing may still be in flight).
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || result_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        item_limit = value;
    endtask

    task automatic run_phase(input logic [7:0] limit, input int n_bytes, input logic quiet);
        int target;
        wait_idle();
        write_limit(limit);
        calm   = quiet;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) make_descriptor();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_wdata             = '0;
        in_if.valid             = 1'b0;
        in_if.in_byte           = '0;
        in_if.end_of_descriptor = 1'b0;
        out_if.ready            = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset limit: one item of every class, a reserved type, and a
        // four-byte vendor page closed by the end mark on its last data byte.
        add_item(8'h05, 32'h01, 1, 1'b0);           // usage page
        add_item(8'h09, 32'h02, 1, 1'b0);           // usage
        add_item(8'hA1, 32'h01, 1, 1'b0);           // collection
        add_item(8'h85, 32'h03, 1, 1'b0);           // report id
        add_item(8'h75, 32'h08, 1, 1'b0);           // report size
        add_item(8'h95, 32'h04, 1, 1'b0);           // report count
        add_item(8'h81, 32'h02, 1, 1'b0);           // input
        add_item(8'h92, 32'h0302, 2, 1'b0);         // output, two data bytes
        add_item(8'hB1, 32'hFF, 1, 1'b0);           // feature
        add_item(8'hC0, 32'h0, 0, 1'b0);            // end collection, no data
        add_item(8'hFC, 32'h0, 0, 1'b0);            // reserved type
        add_item(8'h07, VENDOR_PAGE_MIN, 4, 1'b1);

        // Limit of one: second item dropped, truncation at the limit silent.
        wait_idle();
        write_limit(8'd1);
        add_item(8'h06, 32'hFFFF, 2, 1'b0);
        add_item(8'h05, 32'h02, 1, 1'b0);
        add_item(8'h17, 32'hFFFF_FFFF, 2, 1'b1);

        // Full limit: truncation mid-data and at the prefix, page just below
        // vendor range, zero-size page, end mark on a no-data prefix.
        wait_idle();
        write_limit(8'd255);
        add_item(8'h27, 32'hDEAD_BEEF, 3, 1'b1);
        add_item(8'hFF, 32'h0, 0, 1'b1);
        add_item(8'h06, VENDOR_PAGE_MIN - 32'd1, 2, 1'b0);
        add_item(8'h04, 32'h0, 0, 1'b1);
        add_item(8'h00, 32'h0, 0, 1'b1);

        // Random descriptors over a spread of limits.
        run_phase(8'd255, 250, 1'b0);
        run_phase(8'd0,    60, 1'b0);
        run_phase(8'd3,   120, 1'b0);
        run_phase(8'd20,  150, 1'b1);
        run_phase(8'($urandom_range(1, 40)), 200, 1'b0);
        run_phase(8'd255, 220, 1'b0);

        wait_idle();
        if (!failed) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hdip_pkg.sv
rtl/hdip_in_if.sv
rtl/hdip_out_if.sv
rtl/hdip_front.sv
rtl/hdip_queue.sv
rtl/hdip_back.sv
rtl/hid_descriptor_item_parser_unit.sv
bench/hid_descriptor_item_parser_unit_test.sv
